// ----- rtl/complex_arithmetic_unit_assert.svh -----
// assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("complex arithmetic unit assertion failed");
`define CAU_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error("complex arithmetic unit assertion failed");
`else
`define CAU_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define CAU_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- rtl/cau_pkg.sv -----
`default_nettype none
package cau_pkg;

	typedef enum logic [2:0] {
		OP_ADD      = 3'd0,
		OP_ADD_REAL = 3'd1,
		OP_SUB      = 3'd2,
		OP_MUL      = 3'd3,
		OP_SCALE    = 3'd4,
		OP_DIV      = 3'd5,
		OP_DIV_REAL = 3'd6,
		OP_EQUAL    = 3'd7
	} op_t;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
	} req_t;

	typedef struct packed {
		logic signed [31:0] res_re;
		logic signed [31:0] res_im;
		logic               is_equal;
		logic               div_zero;
		logic               overflow;
	} rsp_t;

	// per item control carried alongside the divider
	typedef struct packed {
		logic [31:0] res_re;
		logic [31:0] res_im;
		logic        is_equal;
		logic        overflow;
		logic        is_div;
		logic        div_zero;
		logic        neg_re;
		logic        neg_im;
	} side_t;

	localparam int QW = 34;

endpackage
`default_nettype wire

// ----- rtl/cau_front.sv -----
`default_nettype none
module cau_front #(
	parameter int FRAC_BITS = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  cau_pkg::req_t              in_data,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [64+FRAC_BITS-1:0]    rem_re,
	output logic [64+FRAC_BITS-1:0]    rem_im,
	output logic [63:0]                dvsr,
	output cau_pkg::side_t             side
);
	import cau_pkg::*;

	localparam int NW = 64 + FRAC_BITS;

	function automatic logic [32:0] sat33(input logic [32:0] x);
		logic ov;
		logic [31:0] v;
		ov = x[32] ^ x[31];
		v = ov ? (x[32] ? 32'h80000000 : 32'h7fffffff) : x[31:0];
		return {ov, v};
	endfunction

	function automatic logic [32:0] sat65(input logic [64:0] x);
		logic ov;
		logic [31:0] v;
		ov = !((&x[64:31]) || !(|x[64:31]));
		v = ov ? (x[64] ? 32'h80000000 : 32'h7fffffff) : x[31:0];
		return {ov, v};
	endfunction

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	// stage 1: products, sums, compare
	logic [2:0]         op_s1;
	logic signed [63:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	logic [31:0]        ar_s1, ai_s1, br_s1;
	side_t              side_s1;

	logic [32:0] sum_re, sum_im;
	logic [32:0] sr_re, sr_im;
	side_t       side_n1;
	logic [32:0] ar_x, ai_x, br_x, bi_x;

	assign ar_x = {in_data.a_re[31], in_data.a_re};
	assign ai_x = {in_data.a_im[31], in_data.a_im};
	assign br_x = {in_data.b_re[31], in_data.b_re};
	assign bi_x = {in_data.b_im[31], in_data.b_im};

	always_comb begin
		case (in_data.op)
			OP_SUB: begin
				sum_re = ar_x - br_x;
				sum_im = ai_x - bi_x;
			end
			OP_ADD_REAL: begin
				sum_re = ar_x + br_x;
				sum_im = ai_x;
			end
			default: begin
				sum_re = ar_x + br_x;
				sum_im = ai_x + bi_x;
			end
		endcase
		sr_re = sat33(sum_re);
		sr_im = sat33(sum_im);
		side_n1 = '0;
		case (in_data.op)
			OP_ADD, OP_ADD_REAL, OP_SUB: begin
				side_n1.res_re = sr_re[31:0];
				side_n1.res_im = sr_im[31:0];
				side_n1.overflow = sr_re[32] | sr_im[32];
			end
			OP_EQUAL: begin
				side_n1.is_equal = (in_data.a_re == in_data.b_re) &&
					(in_data.a_im == in_data.b_im);
			end
			default: begin
				side_n1.is_div = (in_data.op == OP_DIV) || (in_data.op == OP_DIV_REAL);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1 <= in_data.op;
			p0_s1 <= $signed(in_data.a_re) * $signed(in_data.b_re);
			p1_s1 <= $signed(in_data.a_im) * $signed(in_data.b_im);
			p2_s1 <= $signed(in_data.a_re) * $signed(in_data.b_im);
			p3_s1 <= $signed(in_data.a_im) * $signed(in_data.b_re);
			p4_s1 <= $signed(in_data.b_re) * $signed(in_data.b_re);
			p5_s1 <= $signed(in_data.b_im) * $signed(in_data.b_im);
			ar_s1 <= in_data.a_re;
			ai_s1 <= in_data.a_im;
			br_s1 <= in_data.b_re;
			side_s1 <= side_n1;
		end
	end

	// stage 2: product sums and divisor
	logic signed [64:0] re_s2, im_s2;
	logic [63:0]        d_s2;
	logic               bneg_s2;
	logic               fl_s2;
	side_t              side_s2;

	logic [64:0] re_n, im_n;
	logic [63:0] d_n;
	logic [31:0] br_abs;

	assign br_abs = br_s1[31] ? (~br_s1 + 32'd1) : br_s1;

	always_comb begin
		re_n = '0;
		im_n = '0;
		d_n = '0;
		case (op_s1)
			OP_MUL: begin
				re_n = {p0_s1[63], p0_s1} - {p1_s1[63], p1_s1};
				im_n = {p2_s1[63], p2_s1} + {p3_s1[63], p3_s1};
			end
			OP_SCALE: begin
				re_n = {p0_s1[63], p0_s1};
				im_n = {p3_s1[63], p3_s1};
			end
			OP_DIV: begin
				re_n = {p0_s1[63], p0_s1} + {p1_s1[63], p1_s1};
				im_n = {p3_s1[63], p3_s1} - {p2_s1[63], p2_s1};
				d_n = $unsigned(p4_s1) + $unsigned(p5_s1);
			end
			OP_DIV_REAL: begin
				re_n = {{33{ar_s1[31]}}, ar_s1};
				im_n = {{33{ai_s1[31]}}, ai_s1};
				d_n = {32'd0, br_abs};
			end
			default: begin
				re_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			re_s2 <= re_n;
			im_s2 <= im_n;
			d_s2 <= d_n;
			bneg_s2 <= (op_s1 == OP_DIV_REAL) && br_s1[31];
			fl_s2 <= (op_s1 == OP_MUL) || (op_s1 == OP_SCALE);
			side_s2 <= side_s1;
		end
	end

	// stage 3: scale and saturate products, set up the dividend
	logic signed [64:0] fl_re, fl_im;
	logic [32:0]        sm_re, sm_im;
	logic [63:0]        mag_re, mag_im;
	side_t              side_n3;

	assign fl_re = re_s2 >>> FRAC_BITS;
	assign fl_im = im_s2 >>> FRAC_BITS;
	assign sm_re = sat65(fl_re);
	assign sm_im = sat65(fl_im);
	assign mag_re = re_s2[64] ? 64'(-re_s2) : re_s2[63:0];
	assign mag_im = im_s2[64] ? 64'(-im_s2) : im_s2[63:0];

	always_comb begin
		side_n3 = side_s2;
		if (fl_s2) begin
			side_n3.res_re = sm_re[31:0];
			side_n3.res_im = sm_im[31:0];
			side_n3.overflow = sm_re[32] | sm_im[32];
		end
		side_n3.div_zero = side_s2.is_div && (d_s2 == 64'd0);
		side_n3.neg_re = re_s2[64] ^ bneg_s2;
		side_n3.neg_im = im_s2[64] ^ bneg_s2;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			rem_re <= NW'(mag_re) << FRAC_BITS;
			rem_im <= NW'(mag_im) << FRAC_BITS;
			dvsr <= d_s2;
			side <= side_n3;
		end
	end

	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/cau_div.sv -----
`default_nettype none
module cau_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [64+FRAC_BITS-1:0]       rem_re,
	input  wire [64+FRAC_BITS-1:0]       rem_im,
	input  wire [63:0]                   dvsr,
	input  cau_pkg::side_t               in_side,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [cau_pkg::QW-1:0]       q_re,
	output logic [cau_pkg::QW-1:0]       q_im,
	output cau_pkg::side_t               out_side
);
	import cau_pkg::*;

	localparam int NW = 64 + FRAC_BITS;
	localparam int NS = QW;

	logic [NW-1:0] rr_s [NS];
	logic [NW-1:0] ri_s [NS];
	logic [63:0]   d_s  [NS];
	logic [QW-1:0] qr_s [NS];
	logic [QW-1:0] qi_s [NS];
	side_t         sd_s [NS];
	logic          v_s  [NS];
	logic          en   [NS];

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < NS; j++) begin : g_stg
		localparam int K = QW - 1 - j;
		logic [NW-1:0] r_in, i_in;
		logic [63:0]   d_in;
		logic [QW-1:0] qr_in, qi_in;
		side_t         sd_in;
		logic          v_in, nxt_rdy;
		logic          take_r, take_i;

		if (j == 0) begin : g_first
			assign r_in = rem_re;
			assign i_in = rem_im;
			assign d_in = dvsr;
			assign qr_in = '0;
			assign qi_in = '0;
			assign sd_in = in_side;
			assign v_in = in_valid;
		end else begin : g_next
			assign r_in = rr_s[j-1];
			assign i_in = ri_s[j-1];
			assign d_in = d_s[j-1];
			assign qr_in = qr_s[j-1];
			assign qi_in = qi_s[j-1];
			assign sd_in = sd_s[j-1];
			assign v_in = v_s[j-1];
		end

		if (j == NS - 1) begin : g_last
			assign nxt_rdy = out_ready;
		end else begin : g_mid
			assign nxt_rdy = en[j+1];
		end

		assign en[j] = !v_s[j] || nxt_rdy;
		assign take_r = (r_in >> K) >= NW'(d_in);
		assign take_i = (i_in >> K) >= NW'(d_in);

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rr_s[j] <= take_r ? (r_in - (NW'(d_in) << K)) : r_in;
				ri_s[j] <= take_i ? (i_in - (NW'(d_in) << K)) : i_in;
				qr_s[j] <= qr_in | (QW'(take_r) << K);
				qi_s[j] <= qi_in | (QW'(take_i) << K);
				d_s[j] <= d_in;
				sd_s[j] <= sd_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en[j]) begin
				v_s[j] <= v_in;
			end
		end
	end

	assign in_ready = en[0];
	assign out_valid = v_s[NS-1];
	assign q_re = qr_s[NS-1];
	assign q_im = qi_s[NS-1];
	assign out_side = sd_s[NS-1];

endmodule
`default_nettype wire

// ----- rtl/complex_arithmetic_unit.sv -----
// complex arithmetic unit, signed fixed point, one item per cycle while rsp_stall is low
// pipeline: 3 front stages, 34 divider stages and 1 output register between accepted item and result
// throughput: one item per cycle while rsp_stall is low, set by the one-bit-per-stage quotient pipeline
// every item, division or not, takes the same path so results stay in order
// reset clears all valid bits; no results are pending after arst_n is released
`default_nettype none
`include "complex_arithmetic_unit_assert.svh"
module complex_arithmetic_unit #(
	parameter int FRAC_BITS = 16
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_stall,
	input  cau_pkg::req_t  req,
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output cau_pkg::rsp_t  rsp
);
	import cau_pkg::*;

	localparam int NW = 64 + FRAC_BITS;

	function automatic logic [32:0] sat_q(input logic neg, input logic [QW-1:0] mag);
		logic ov;
		logic [31:0] v;
		if (!neg) begin
			ov = mag > QW'(32'h7fffffff);
			v = ov ? 32'h7fffffff : mag[31:0];
		end else begin
			ov = mag > QW'(32'h80000000);
			v = ov ? 32'h80000000 : (~mag[31:0] + 32'd1);
		end
		return {ov, v};
	endfunction

	logic          f_ready, f_valid;
	logic [NW-1:0] f_rem_re, f_rem_im;
	logic [63:0]   f_dvsr;
	side_t         f_side;

	logic          d_valid, d_ready;
	logic [QW-1:0] d_q_re, d_q_im;
	side_t         d_side;

	logic d_in_ready;

	cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_valid),
		.in_ready  (f_ready),
		.in_data   (req),
		.out_valid (f_valid),
		.out_ready (d_in_ready),
		.rem_re    (f_rem_re),
		.rem_im    (f_rem_im),
		.dvsr      (f_dvsr),
		.side      (f_side)
	);

	cau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (d_in_ready),
		.rem_re    (f_rem_re),
		.rem_im    (f_rem_im),
		.dvsr      (f_dvsr),
		.in_side   (f_side),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.q_re      (d_q_re),
		.q_im      (d_q_im),
		.out_side  (d_side)
	);

	assign req_stall = !f_ready;

	// output stage
	logic        valid_q;
	rsp_t        rsp_q;
	rsp_t        rsp_n;
	logic [32:0] qs_re, qs_im;

	assign qs_re = sat_q(d_side.neg_re, d_q_re);
	assign qs_im = sat_q(d_side.neg_im, d_q_im);

	always_comb begin
		rsp_n.res_re = d_side.res_re;
		rsp_n.res_im = d_side.res_im;
		rsp_n.is_equal = d_side.is_equal;
		rsp_n.div_zero = 1'b0;
		rsp_n.overflow = d_side.overflow;
		if (d_side.is_div) begin
			if (d_side.div_zero) begin
				rsp_n.res_re = '0;
				rsp_n.res_im = '0;
				rsp_n.div_zero = 1'b1;
				rsp_n.overflow = 1'b0;
			end else begin
				rsp_n.res_re = qs_re[31:0];
				rsp_n.res_im = qs_im[31:0];
				rsp_n.overflow = qs_re[32] | qs_im[32];
			end
		end
	end

	assign d_ready = !valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		if (d_ready) begin
			rsp_q <= rsp_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (d_ready) begin
			valid_q <= d_valid;
		end
	end

	assign rsp_valid = valid_q;
	assign rsp = rsp_q;

	`CAU_ASSERT_IMP(a_dz_zero, clk, arst_n, rsp_valid && rsp.div_zero, rsp.res_re == '0 && rsp.res_im == '0 && !rsp.overflow)
	`CAU_ASSERT_IMP(a_flag_excl, clk, arst_n, rsp_valid, !(rsp.is_equal && (rsp.div_zero || rsp.overflow)))
	`CAU_ASSERT_IMP(a_stall_full, clk, arst_n, req_stall, rsp_valid && rsp_stall)

endmodule
`default_nettype wire

// ----- verif/complex_arithmetic_unit_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module complex_arithmetic_unit_tb;
	import cau_pkg::*;

	localparam int FRAC = 16;
	localparam int LATENCY = 38;
	localparam int STALL_LIMIT = 20000;
	localparam int N_RANDOM = 1150;
	localparam logic [31:0] MAXP = 32'h7fffffff;
	localparam logic [31:0] MINN = 32'h80000000;
	localparam logic [31:0] ONE = 32'h00010000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b1;
	rsp_t rsp;

	rsp_t result_q[$];
	int errors = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	bit running = 1'b0;

	complex_arithmetic_unit #(.FRAC_BITS(FRAC)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic ov);
		if (v > 128'sh7fffffff) begin
			ov = 1'b1;
			return MAXP;
		end
		if (v < -128'sh80000000) begin
			ov = 1'b1;
			return MINN;
		end
		return v[31:0];
	endfunction

	// product sum scaled down, rounding toward minus infinity
	function automatic logic [31:0] scale_down(input logic signed [127:0] v, inout logic ov);
		return clamp(v >>> FRAC, ov);
	endfunction

	// quotient truncated toward zero
	function automatic logic [31:0] quot(input logic signed [127:0] n,
			input logic signed [127:0] d, inout logic ov);
		logic signed [127:0] num;
		logic [127:0] mn, md, q;
		logic neg;
		num = n <<< FRAC;
		neg = (num < 0) != (d < 0);
		mn = (num < 0) ? -num : num;
		md = (d < 0) ? -d : d;
		q = mn / md;
		return clamp(neg ? -$signed(q) : $signed(q), ov);
	endfunction

	function automatic rsp_t predict_complex(input req_t r);
		rsp_t e;
		logic signed [127:0] ar, ai, br, bi, den;
		logic ov;
		e = '0;
		ov = 1'b0;
		ar = r.a_re;
		ai = r.a_im;
		br = r.b_re;
		bi = r.b_im;
		case (op_t'(r.op))
			OP_ADD: begin
				e.res_re = clamp(ar + br, ov);
				e.res_im = clamp(ai + bi, ov);
			end
			OP_ADD_REAL: begin
				e.res_re = clamp(ar + br, ov);
				e.res_im = r.a_im;
			end
			OP_SUB: begin
				e.res_re = clamp(ar - br, ov);
				e.res_im = clamp(ai - bi, ov);
			end
			OP_MUL: begin
				e.res_re = scale_down(ar * br - ai * bi, ov);
				e.res_im = scale_down(ar * bi + ai * br, ov);
			end
			OP_SCALE: begin
				e.res_re = scale_down(ar * br, ov);
				e.res_im = scale_down(ai * br, ov);
			end
			OP_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) e.div_zero = 1'b1;
				else begin
					e.res_re = quot(ar * br + ai * bi, den, ov);
					e.res_im = quot(ai * br - ar * bi, den, ov);
				end
			end
			OP_DIV_REAL: begin
				if (br == 0) e.div_zero = 1'b1;
				else begin
					e.res_re = quot(ar, br, ov);
					e.res_im = quot(ai, br, ov);
				end
			end
			default: e.is_equal = (ar == br) && (ai == bi);
		endcase
		e.overflow = ov;
		return e;
	endfunction

	function automatic logic [31:0] rand_part();
		case ($urandom_range(0, 9))
			0: return MAXP;
			1: return MINN;
			2: return 32'($signed($urandom_range(0, 8)) - 4) << FRAC;
			3, 4: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
			5, 6: return 32'($signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000);
			default: return $urandom;
		endcase
	endfunction

	// directed rows: stimulus with a typed-in expectation where obvious
	typedef struct {
		req_t stim;
		bit known;
		rsp_t want;
	} row_t;

	row_t rows[$];

	function automatic row_t mk(input op_t op, input logic [31:0] ar, input logic [31:0] ai,
			input logic [31:0] br, input logic [31:0] bi);
		row_t r;
		r.stim = '{op: op, a_re: ar, a_im: ai, b_re: br, b_im: bi};
		r.known = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic row_t mkk(input op_t op, input logic [31:0] ar, input logic [31:0] ai,
			input logic [31:0] br, input logic [31:0] bi, input logic [31:0] rr,
			input logic [31:0] ri, input logic eq, input logic dz, input logic ov);
		row_t r;
		r = mk(op, ar, ai, br, bi);
		r.known = 1'b1;
		r.want = '{res_re: rr, res_im: ri, is_equal: eq, div_zero: dz, overflow: ov};
		return r;
	endfunction

	initial begin
		rows.push_back(mkk(OP_ADD, MAXP, MINN, MAXP, MINN, MAXP, MINN, 0, 0, 1));
		rows.push_back(mkk(OP_ADD, ONE, ONE, ONE, ONE, 32'h20000, 32'h20000, 0, 0, 0));
		rows.push_back(mkk(OP_ADD_REAL, MAXP, MINN, ONE, MAXP, MAXP, MINN, 0, 0, 1));
		rows.push_back(mkk(OP_SUB, MINN, MAXP, ONE, MINN, MINN, MAXP, 0, 0, 1));
		rows.push_back(mkk(OP_SUB, ONE, 0, ONE, 0, 0, 0, 0, 0, 0));
		rows.push_back(mkk(OP_MUL, MAXP, MAXP, MAXP, MINN, MAXP, 32'hffff8000, 0, 0, 1));
		rows.push_back(mkk(OP_MUL, ONE, 0, ONE, 0, ONE, 0, 0, 0, 0));
		rows.push_back(mk(OP_MUL, MINN, MINN, MINN, MINN));
		rows.push_back(mk(OP_MUL, 32'hffffffff, 1, 1, 32'hffffffff));
		rows.push_back(mkk(OP_SCALE, MAXP, MINN, ONE, 0, MAXP, MINN, 0, 0, 0));
		rows.push_back(mk(OP_SCALE, MINN, MAXP, MINN, 0));
		rows.push_back(mk(OP_SCALE, 32'hffffffff, 1, 1, 0));
		rows.push_back(mkk(OP_DIV, MAXP, MINN, 0, 0, 0, 0, 0, 1, 0));
		rows.push_back(mkk(OP_DIV, ONE, ONE, ONE, 0, ONE, ONE, 0, 0, 0));
		rows.push_back(mk(OP_DIV, MAXP, MINN, 1, 1));
		rows.push_back(mk(OP_DIV, MINN, MINN, MINN, MINN));
		rows.push_back(mk(OP_DIV, 32'hfffffffd, 7, 3, 32'hfffffffb));
		rows.push_back(mkk(OP_DIV_REAL, MAXP, MINN, 0, MAXP, 0, 0, 0, 1, 0));
		rows.push_back(mkk(OP_DIV_REAL, MAXP, MINN, 1, 0, MAXP, MINN, 0, 0, 1));
		rows.push_back(mk(OP_DIV_REAL, MINN, MAXP, 32'hffffffff, 5));
		rows.push_back(mk(OP_DIV_REAL, 32'hfffffffd, 3, 32'h20000, 0));
		rows.push_back(mkk(OP_EQUAL, MAXP, MINN, MAXP, MINN, 0, 0, 1, 0, 0));
		rows.push_back(mkk(OP_EQUAL, MAXP, MINN, MAXP, MAXP, 0, 0, 0, 0, 0));
		rows.push_back(mkk(OP_EQUAL, 0, 0, 0, 0, 0, 0, 1, 0, 0));
	end

	task automatic send_item(input req_t r, input bit known, input rsp_t want);
		while (!quiet && ($urandom_range(0, 99) < 29)) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		result_q.push_back(known ? want : predict_complex(r));
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		if (running) rsp_stall <= !quiet && ($urandom_range(0, 99) < 29);
	end

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (rsp_valid && !rsp_stall) begin
				if (result_q.size() == 0) begin
					$error("result with none expected: %p", rsp);
					errors++;
				end else begin
					e = result_q.pop_front();
					if (rsp.res_re !== e.res_re) begin
						$error("res_re expected %h actual %h", e.res_re, rsp.res_re);
						errors++;
					end
					if (rsp.res_im !== e.res_im) begin
						$error("res_im expected %h actual %h", e.res_im, rsp.res_im);
						errors++;
					end
					if (rsp.is_equal !== e.is_equal) begin
						$error("is_equal expected %b actual %b", e.is_equal, rsp.is_equal);
						errors++;
					end
					if (rsp.div_zero !== e.div_zero) begin
						$error("div_zero expected %b actual %b", e.div_zero, rsp.div_zero);
						errors++;
					end
					if (rsp.overflow !== e.overflow) begin
						$error("overflow expected %b actual %b", e.overflow, rsp.overflow);
						errors++;
					end
				end
			end
			if (idle_cycles > STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		req_t r;
		rsp_t none;
		int k;
		none = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		running <= 1'b1;
		@(negedge clk);
		foreach (rows[i]) send_item(rows[i].stim, rows[i].known, rows[i].want);
		for (k = 0; k < N_RANDOM; k++) begin
			quiet = (k >= 400 && k < 550);
			r.op = 3'($urandom_range(0, 7));
			r.a_re = rand_part();
			r.a_im = rand_part();
			r.b_re = rand_part();
			r.b_im = rand_part();
			if (r.op == OP_EQUAL && $urandom_range(0, 1)) begin
				r.b_re = r.a_re;
				if ($urandom_range(0, 2) != 0) r.b_im = r.a_im;
			end
			if ((r.op == OP_DIV || r.op == OP_DIV_REAL) && $urandom_range(0, 9) == 0) begin
				r.b_re = '0;
				if ($urandom_range(0, 1)) r.b_im = '0;
			end
			send_item(r, 1'b0, none);
		end
		req_valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
